/* rtl/core/box_plane_contact_generator_assert.svh */
// assertion macros for the box plane contact generator checkers
// expects clk_i and rst_ni in the scope of use
`ifndef BOX_PLANE_CONTACT_GENERATOR_ASSERT_SVH
`define BOX_PLANE_CONTACT_GENERATOR_ASSERT_SVH

// condition implies consequence in the same cycle
`define BPC_ASSERT_NOW(lbl, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error("bpc assertion failed");

// condition implies consequence in the following cycle
`define BPC_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error("bpc assertion failed");

`endif

/* rtl/core/bpc_pkg.sv */
// shared widths, register indexes and reset values of the box plane contact generator
// no dependencies
`default_nettype none
package bpc_pkg;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned Q_W     = 16;
  localparam int unsigned HALF_W  = 31;
  localparam int unsigned BIAS_W  = 15;
  localparam int unsigned DEPTH_W = 31;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 4;

  typedef enum logic [1:0] {
    REG_HALF_X    = 2'd0,
    REG_HALF_Y    = 2'd1,
    REG_HALF_Z    = 2'd2,
    REG_ZERO_BIAS = 2'd3
  } reg_idx_e;

  localparam logic [HALF_W-1:0] HALF_RST = 31'd65536;
  localparam logic [BIAS_W-1:0] BIAS_RST = 15'd16;
endpackage
`default_nettype wire

/* rtl/core/bpc_in_if.sv */
// input channel of the box plane contact generator: box pose and plane
// depends on bpc_pkg
`default_nettype none
interface bpc_in_if ();
  logic valid;
  logic ready;
  logic signed [bpc_pkg::POS_W-1:0] pos_x;
  logic signed [bpc_pkg::POS_W-1:0] pos_y;
  logic signed [bpc_pkg::POS_W-1:0] pos_z;
  logic signed [bpc_pkg::Q_W-1:0]   quat_w;
  logic signed [bpc_pkg::Q_W-1:0]   quat_x;
  logic signed [bpc_pkg::Q_W-1:0]   quat_y;
  logic signed [bpc_pkg::Q_W-1:0]   quat_z;
  logic signed [bpc_pkg::Q_W-1:0]   normal_x;
  logic signed [bpc_pkg::Q_W-1:0]   normal_y;
  logic signed [bpc_pkg::Q_W-1:0]   normal_z;
  logic signed [bpc_pkg::POS_W-1:0] plane_offset;

  modport source (output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                  normal_x, normal_y, normal_z, plane_offset, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                normal_x, normal_y, normal_z, plane_offset, output ready);
endinterface
`default_nettype wire

/* rtl/core/bpc_out_if.sv */
// output channel of the box plane contact generator: up to four contacts per item, or one empty result
// depends on bpc_pkg
`default_nettype none
interface bpc_out_if ();
  logic valid;
  logic ready;
  logic signed [bpc_pkg::POS_W-1:0] contact_x;
  logic signed [bpc_pkg::POS_W-1:0] contact_y;
  logic signed [bpc_pkg::POS_W-1:0] contact_z;
  logic signed [bpc_pkg::Q_W-1:0]   contact_normal_x;
  logic signed [bpc_pkg::Q_W-1:0]   contact_normal_y;
  logic signed [bpc_pkg::Q_W-1:0]   contact_normal_z;
  logic [bpc_pkg::DEPTH_W-1:0]      depth;
  logic                             contact_valid;
  logic                             last;

  modport source (output valid, contact_x, contact_y, contact_z, contact_normal_x,
                  contact_normal_y, contact_normal_z, depth, contact_valid, last,
                  input ready);
  modport sink (input valid, contact_x, contact_y, contact_z, contact_normal_x,
                contact_normal_y, contact_normal_z, depth, contact_valid, last,
                output ready);
endinterface
`default_nettype wire

/* rtl/core/box_plane_contact_generator.sv */
// box against plane contact generator, nine stage pipeline plus result slot and output register
// path: an item passes stages 1 to 9, then the result slot, then the output register
// throughput: one result item per cycle while the receiver is ready; an item with n results (1 to 4)
//   holds the result slot until all n have left, so items with one result can enter every cycle
// reset: asynchronous active low, clears valid bits and loads register defaults
`default_nettype none
module box_plane_contact_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bpc_in_if.sink                        in_i,
  bpc_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpc_pkg::APB_AW-1:0]    paddr,
  input  logic [bpc_pkg::APB_DW-1:0]    pwdata,
  output logic [bpc_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  // configuration
  logic [bpc_pkg::HALF_W-1:0] half_q [3];
  logic [bpc_pkg::BIAS_W-1:0] bias_q;
  bpc_pkg::reg_idx_e          reg_idx;
  logic                       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = bpc_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q[0] <= bpc_pkg::HALF_RST;
      half_q[1] <= bpc_pkg::HALF_RST;
      half_q[2] <= bpc_pkg::HALF_RST;
      bias_q    <= bpc_pkg::BIAS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        bpc_pkg::REG_HALF_X:    half_q[0] <= pwdata[bpc_pkg::HALF_W-1:0];
        bpc_pkg::REG_HALF_Y:    half_q[1] <= pwdata[bpc_pkg::HALF_W-1:0];
        bpc_pkg::REG_HALF_Z:    half_q[2] <= pwdata[bpc_pkg::HALF_W-1:0];
        bpc_pkg::REG_ZERO_BIAS: bias_q    <= pwdata[bpc_pkg::BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bpc_pkg::REG_HALF_X:    prdata = {1'b0, half_q[0]};
      bpc_pkg::REG_HALF_Y:    prdata = {1'b0, half_q[1]};
      bpc_pkg::REG_HALF_Z:    prdata = {1'b0, half_q[2]};
      bpc_pkg::REG_ZERO_BIAS: prdata = {17'd0, bias_q};
      default:                prdata = '0;
    endcase
  end

  // pipeline control
  logic adv;
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, s7_v_q, s8_v_q, s9_v_q;
  logic slot_v_q, slot_done, emit, out_v_q, out_free;

  assign in_i.ready = adv;

  // stage 1: captured item
  logic signed [31:0] s1_p_q [3];
  logic signed [15:0] s1_n_q [3];
  logic signed [15:0] s1_qt_q [4];
  logic signed [31:0] s1_off_q;

  // stage 2: first products
  logic signed [47:0] s2_np_d [3], s2_np_q [3];
  logic signed [31:0] s2_qq_d [9], s2_qq_q [9];
  logic [61:0]        s2_hh_d [3], s2_hh_q [3];
  logic signed [31:0] s2_p_q [3];
  logic signed [15:0] s2_n_q [3];
  logic signed [31:0] s2_off_q;

  // stage 3: center distance, rotation matrix, squared extent
  logic signed [49:0] s3_sum;
  logic signed [36:0] s3_d_d, s3_d_q;
  logic signed [19:0] s3_m_d [3][3], s3_m_q [3][3];
  logic [63:0]        s3_hs_d, s3_hs_q;
  logic signed [31:0] s3_p_q [3];
  logic signed [15:0] s3_n_q [3];
  logic signed [31:0] s3_off_q;

  // stage 4: squared distance, local normal products, matrix times extents
  logic [63:0]        s4_dd_d, s4_dd_q, s4_hs_q;
  logic               s4_far_d, s4_far_q;
  logic signed [35:0] s4_mn_d [3][3], s4_mn_q [3][3];
  logic signed [51:0] s4_mh_d [3][3], s4_mh_q [3][3];
  logic signed [31:0] s4_p_q [3];
  logic signed [15:0] s4_n_q [3];
  logic signed [31:0] s4_off_q;

  // stage 5: rejection and axis classes
  logic               s5_rej_d, s5_rej_q;
  logic [2:0]         s5_split_d, s5_split_q, s5_neg_d, s5_neg_q;
  logic signed [51:0] s5_mh_q [3][3];
  logic signed [31:0] s5_p_q [3];
  logic signed [15:0] s5_n_q [3];
  logic signed [31:0] s5_off_q;

  // stage 6: world corners of four lanes
  logic [2:0]         lane_neg [4];
  logic [1:0]         s6_ns_d, s6_ns_q;
  logic signed [40:0] s6_w_d [4][3], s6_w_q [4][3];
  logic               s6_rej_q;
  logic signed [15:0] s6_n_q [3];
  logic signed [31:0] s6_off_q;

  // stage 7: normal times corner
  logic signed [56:0] s7_nw_d [4][3], s7_nw_q [4][3];
  logic signed [40:0] s7_w_q [4][3];
  logic [1:0]         s7_ns_q;
  logic               s7_rej_q;
  logic signed [15:0] s7_n_q [3];
  logic signed [31:0] s7_off_q;

  // stage 8: depth per lane
  logic signed [46:0] s8_dep_d [4], s8_dep_q [4];
  logic signed [40:0] s8_w_q [4][3];
  logic [1:0]         s8_ns_q;
  logic               s8_rej_q;
  logic signed [15:0] s8_n_q [3];

  // stage 9: normal times depth
  logic signed [62:0] s9_nd_d [4][3], s9_nd_q [4][3];
  logic signed [46:0] s9_dep_q [4];
  logic signed [40:0] s9_w_q [4][3];
  logic [1:0]         s9_ns_q;
  logic               s9_rej_q;
  logic signed [15:0] s9_n_q [3];

  // result slot
  logic signed [31:0] slot_cp_d [4][3], slot_cp_q [4][3];
  logic [30:0]        slot_dep_d [4], slot_dep_q [4];
  logic signed [15:0] slot_n_q [3];
  logic [1:0]         slot_cnt_d, slot_cnt_q, slot_idx_q;
  logic               slot_empty_d, slot_empty_q, slot_load;

  function automatic logic signed [19:0] mat_diag(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [34:0] t;
    t = (35'sd1 <<< 28) - ((35'(a) + 35'(b)) <<< 1);
    return $signed(t[33:14]);
  endfunction

  function automatic logic signed [19:0] mat_off(input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  input logic sub);
    logic signed [34:0] t;
    t = sub ? ((35'(a) - 35'(b)) <<< 1) : ((35'(a) + 35'(b)) <<< 1);
    return $signed(t[33:14]);
  endfunction

  assign out_free  = !out_v_q | out_o.ready;
  assign emit      = slot_v_q & out_free;
  assign slot_done = emit & (slot_idx_q == slot_cnt_q);
  assign adv       = !s9_v_q | !slot_v_q | slot_done;
  assign slot_load = adv & s9_v_q;

  always_comb begin
    // stage 2
    for (int i = 0; i < 3; i++) begin
      s2_np_d[i] = 48'(s1_n_q[i]) * 48'(s1_p_q[i]);
      s2_hh_d[i] = 62'(half_q[i]) * 62'(half_q[i]);
    end
    s2_qq_d[0] = 32'(s1_qt_q[1]) * 32'(s1_qt_q[1]);
    s2_qq_d[1] = 32'(s1_qt_q[2]) * 32'(s1_qt_q[2]);
    s2_qq_d[2] = 32'(s1_qt_q[3]) * 32'(s1_qt_q[3]);
    s2_qq_d[3] = 32'(s1_qt_q[1]) * 32'(s1_qt_q[2]);
    s2_qq_d[4] = 32'(s1_qt_q[1]) * 32'(s1_qt_q[3]);
    s2_qq_d[5] = 32'(s1_qt_q[2]) * 32'(s1_qt_q[3]);
    s2_qq_d[6] = 32'(s1_qt_q[0]) * 32'(s1_qt_q[1]);
    s2_qq_d[7] = 32'(s1_qt_q[0]) * 32'(s1_qt_q[2]);
    s2_qq_d[8] = 32'(s1_qt_q[0]) * 32'(s1_qt_q[3]);

    // stage 3
    s3_sum  = 50'(s2_np_q[0]) + 50'(s2_np_q[1]) + 50'(s2_np_q[2]);
    s3_d_d  = 37'($signed(s3_sum[49:14])) + 37'(s2_off_q);
    s3_hs_d = 64'(s2_hh_q[0]) + 64'(s2_hh_q[1]) + 64'(s2_hh_q[2]);
    s3_m_d[0][0] = mat_diag(s2_qq_q[1], s2_qq_q[2]);
    s3_m_d[0][1] = mat_off(s2_qq_q[3], s2_qq_q[8], 1'b1);
    s3_m_d[0][2] = mat_off(s2_qq_q[4], s2_qq_q[7], 1'b0);
    s3_m_d[1][0] = mat_off(s2_qq_q[3], s2_qq_q[8], 1'b0);
    s3_m_d[1][1] = mat_diag(s2_qq_q[0], s2_qq_q[2]);
    s3_m_d[1][2] = mat_off(s2_qq_q[5], s2_qq_q[6], 1'b1);
    s3_m_d[2][0] = mat_off(s2_qq_q[4], s2_qq_q[7], 1'b1);
    s3_m_d[2][1] = mat_off(s2_qq_q[5], s2_qq_q[6], 1'b0);
    s3_m_d[2][2] = mat_diag(s2_qq_q[0], s2_qq_q[1]);

    // stage 4
    s4_dd_d  = 64'(s3_d_q[31:0]) * 64'(s3_d_q[31:0]);
    s4_far_d = s3_d_q[36] | (|s3_d_q[35:32]);
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        s4_mn_d[a][b] = 36'(s3_m_q[a][b]) * 36'(s3_n_q[a]);
        s4_mh_d[a][b] = 52'(s3_m_q[a][b]) * $signed({21'd0, half_q[b]});
      end
    end
  end

  // stage 5: local normal and classification
  logic signed [37:0] ln_sum [3];
  logic signed [23:0] ln [3];
  logic signed [23:0] bias_s;

  always_comb begin
    bias_s   = $signed({9'd0, bias_q});
    s5_rej_d = s4_far_q | (s4_dd_q > s4_hs_q);
    for (int i = 0; i < 3; i++) begin
      ln_sum[i] = 38'(s4_mn_q[0][i]) + 38'(s4_mn_q[1][i]) + 38'(s4_mn_q[2][i]);
      ln[i]     = $signed(ln_sum[i][37:14]);
      s5_neg_d[i]   = ln[i] > bias_s;
      s5_split_d[i] = !(ln[i] < -bias_s) && !(ln[i] > bias_s);
    end
  end

  // stage 6: corner signs per lane, split axes take lane bits in axis order
  logic signed [53:0] w_sum [4][3];

  always_comb begin
    s6_ns_d = 2'(s5_split_q[0]) + 2'(s5_split_q[1]) + 2'(s5_split_q[2]);
    for (int k = 0; k < 4; k++) begin
      lane_neg[k][0] = s5_split_q[0] ? k[0] : s5_neg_q[0];
      lane_neg[k][1] = s5_split_q[1] ? (s5_split_q[0] ? k[1] : k[0]) : s5_neg_q[1];
      lane_neg[k][2] = s5_split_q[2] ? ((s5_split_q[0] | s5_split_q[1]) ? k[1] : k[0])
                                     : s5_neg_q[2];
      for (int i = 0; i < 3; i++) begin
        w_sum[k][i] = '0;
        for (int j = 0; j < 3; j++) begin
          w_sum[k][i] = w_sum[k][i] + (lane_neg[k][j] ? -54'(s5_mh_q[i][j])
                                                      : 54'(s5_mh_q[i][j]));
        end
        s6_w_d[k][i] = 41'(s5_p_q[i]) + 41'($signed(w_sum[k][i][53:14]));
      end
    end
  end

  // stages 7 to 9
  logic signed [58:0] pd_sum [4];
  logic signed [45:0] pd [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        s7_nw_d[k][i] = 57'(s6_n_q[i]) * 57'(s6_w_q[k][i]);
        s9_nd_d[k][i] = 63'(s8_n_q[i]) * 63'(s8_dep_q[k]);
      end
      pd_sum[k]   = 59'(s7_nw_q[k][0]) + 59'(s7_nw_q[k][1]) + 59'(s7_nw_q[k][2]);
      pd[k]       = 46'($signed(pd_sum[k][58:14])) + 46'(s7_off_q);
      s8_dep_d[k] = -47'(pd[k]);
    end
  end

  // slot fill: projection, saturation and contact count
  logic signed [49:0] cp_full [4][3];
  logic [3:0]         lane_ok;
  logic [2:0]         cnt;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        cp_full[k][i] = 50'(s9_w_q[k][i]) - 50'($signed(s9_nd_q[k][i][62:14]));
        if (cp_full[k][i] > 50'sd2147483647) begin
          slot_cp_d[k][i] = 32'sh7FFFFFFF;
        end else if (cp_full[k][i] < -50'sd2147483648) begin
          slot_cp_d[k][i] = 32'sh80000000;
        end else begin
          slot_cp_d[k][i] = cp_full[k][i][31:0];
        end
      end
      slot_dep_d[k] = (s9_dep_q[k] > 47'sd2147483647) ? 31'h7FFFFFFF : s9_dep_q[k][30:0];
      lane_ok[k] = s9_dep_q[k] > 47'sd0;
    end
    lane_ok[1] = lane_ok[1] & (s9_ns_q != 2'd0);
    lane_ok[2] = lane_ok[2] & s9_ns_q[1];
    lane_ok[3] = lane_ok[3] & s9_ns_q[1];
    if (!lane_ok[0]) begin
      cnt = 3'd0;
    end else if (!lane_ok[1]) begin
      cnt = 3'd1;
    end else if (!lane_ok[2]) begin
      cnt = 3'd2;
    end else if (!lane_ok[3]) begin
      cnt = 3'd3;
    end else begin
      cnt = 3'd4;
    end
    slot_empty_d = s9_rej_q | (s9_ns_q == 2'd3) | (cnt == 3'd0);
    slot_cnt_d   = slot_empty_d ? 2'd0 : 2'(cnt - 3'd1);
  end

  // valid bits and handshake state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0; s2_v_q <= 1'b0; s3_v_q <= 1'b0;
      s4_v_q <= 1'b0; s5_v_q <= 1'b0; s6_v_q <= 1'b0;
      s7_v_q <= 1'b0; s8_v_q <= 1'b0; s9_v_q <= 1'b0;
      slot_v_q   <= 1'b0;
      slot_idx_q <= 2'd0;
      out_v_q    <= 1'b0;
    end else begin
      if (adv) begin
        s1_v_q <= in_i.valid; s2_v_q <= s1_v_q; s3_v_q <= s2_v_q;
        s4_v_q <= s3_v_q; s5_v_q <= s4_v_q; s6_v_q <= s5_v_q;
        s7_v_q <= s6_v_q; s8_v_q <= s7_v_q; s9_v_q <= s8_v_q;
      end
      if (slot_load) begin
        slot_v_q <= 1'b1;
      end else if (slot_done) begin
        slot_v_q <= 1'b0;
      end
      if (slot_done) begin
        slot_idx_q <= 2'd0;
      end else if (emit) begin
        slot_idx_q <= slot_idx_q + 2'd1;
      end
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_p_q[0]  <= in_i.pos_x;    s1_p_q[1]  <= in_i.pos_y;    s1_p_q[2]  <= in_i.pos_z;
      s1_n_q[0]  <= in_i.normal_x; s1_n_q[1]  <= in_i.normal_y; s1_n_q[2]  <= in_i.normal_z;
      s1_qt_q[0] <= in_i.quat_w;   s1_qt_q[1] <= in_i.quat_x;
      s1_qt_q[2] <= in_i.quat_y;   s1_qt_q[3] <= in_i.quat_z;
      s1_off_q   <= in_i.plane_offset;

      s2_np_q  <= s2_np_d;  s2_qq_q <= s2_qq_d; s2_hh_q <= s2_hh_d;
      s2_p_q   <= s1_p_q;   s2_n_q  <= s1_n_q;  s2_off_q <= s1_off_q;

      s3_d_q   <= s3_d_d;   s3_m_q  <= s3_m_d;  s3_hs_q <= s3_hs_d;
      s3_p_q   <= s2_p_q;   s3_n_q  <= s2_n_q;  s3_off_q <= s2_off_q;

      s4_dd_q  <= s4_dd_d;  s4_far_q <= s4_far_d; s4_hs_q <= s3_hs_q;
      s4_mn_q  <= s4_mn_d;  s4_mh_q  <= s4_mh_d;
      s4_p_q   <= s3_p_q;   s4_n_q   <= s3_n_q;   s4_off_q <= s3_off_q;

      s5_rej_q <= s5_rej_d; s5_split_q <= s5_split_d; s5_neg_q <= s5_neg_d;
      s5_mh_q  <= s4_mh_q;
      s5_p_q   <= s4_p_q;   s5_n_q   <= s4_n_q;   s5_off_q <= s4_off_q;

      s6_w_q   <= s6_w_d;   s6_ns_q  <= s6_ns_d;  s6_rej_q <= s5_rej_q;
      s6_n_q   <= s5_n_q;   s6_off_q <= s5_off_q;

      s7_nw_q  <= s7_nw_d;  s7_w_q   <= s6_w_q;   s7_ns_q  <= s6_ns_q;
      s7_rej_q <= s6_rej_q; s7_n_q   <= s6_n_q;   s7_off_q <= s6_off_q;

      s8_dep_q <= s8_dep_d; s8_w_q   <= s7_w_q;   s8_ns_q  <= s7_ns_q;
      s8_rej_q <= s7_rej_q; s8_n_q   <= s7_n_q;

      s9_nd_q  <= s9_nd_d;  s9_dep_q <= s8_dep_q; s9_w_q   <= s8_w_q;
      s9_ns_q  <= s8_ns_q;  s9_rej_q <= s8_rej_q; s9_n_q   <= s8_n_q;
    end
    if (slot_load) begin
      slot_cp_q    <= slot_cp_d;
      slot_dep_q   <= slot_dep_d;
      slot_n_q     <= s9_n_q;
      slot_cnt_q   <= slot_cnt_d;
      slot_empty_q <= slot_empty_d;
    end
    if (emit) begin
      out_o.contact_x        <= slot_empty_q ? '0 : slot_cp_q[slot_idx_q][0];
      out_o.contact_y        <= slot_empty_q ? '0 : slot_cp_q[slot_idx_q][1];
      out_o.contact_z        <= slot_empty_q ? '0 : slot_cp_q[slot_idx_q][2];
      out_o.contact_normal_x <= slot_empty_q ? '0 : slot_n_q[0];
      out_o.contact_normal_y <= slot_empty_q ? '0 : slot_n_q[1];
      out_o.contact_normal_z <= slot_empty_q ? '0 : slot_n_q[2];
      out_o.depth            <= slot_empty_q ? '0 : slot_dep_q[slot_idx_q];
      out_o.contact_valid    <= !slot_empty_q;
      out_o.last             <= slot_idx_q == slot_cnt_q;
    end
  end

  assign out_o.valid = out_v_q;

endmodule
`default_nettype wire

/* rtl/core/bpc_checker.sv */
// port level checks of the box plane contact generator, bound to the top level
// depends on bpc_pkg and box_plane_contact_generator_assert.svh
`default_nettype none
module bpc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         contact_valid,
  input logic                         last,
  input logic [bpc_pkg::DEPTH_W-1:0]  depth,
  input logic                         pready
);
`include "box_plane_contact_generator_assert.svh"

  `BPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `BPC_ASSERT_NOW(a_empty_alone, out_valid && !contact_valid, last && depth == '0)
  `BPC_ASSERT_NOW(a_contact_depth, out_valid && contact_valid, depth != '0)
  `BPC_ASSERT_NOW(a_pready_high, 1'b1, pready)

endmodule

bind box_plane_contact_generator bpc_checker u_bpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .contact_valid (out_o.contact_valid),
  .last          (out_o.last),
  .depth         (out_o.depth),
  .pready        (pready)
);
`default_nettype wire

/* test/tb_top.sv */
// testbench for box_plane_contact_generator: random and directed poses, apb register phases
// depends on bpc_pkg, bpc_in_if, bpc_out_if and the block itself
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  typedef struct {
    logic signed [31:0] px, py, pz, off;
    logic signed [15:0] qw, qx, qy, qz, nx, ny, nz;
  } pose_t;

  typedef struct {
    logic signed [31:0] cx, cy, cz;
    logic signed [15:0] nx, ny, nz;
    logic [30:0] depth;
    logic cvalid, last;
  } contact_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [bpc_pkg::APB_AW-1:0] paddr = '0;
  logic [bpc_pkg::APB_DW-1:0] pwdata = '0;
  logic [bpc_pkg::APB_DW-1:0] prdata;
  logic pready;

  bpc_in_if in_ch ();
  bpc_out_if out_ch ();

  box_plane_contact_generator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  longint hx = 65536, hy = 65536, hz = 65536, zbias = 16;
  pose_t pending_poses[$];
  contact_t expected_contacts[$];
  int errors = 0;
  int accepted = 0;
  bit src_idle_on = 1'b1, sink_idle_on = 1'b1;
  bit sink_hold = 1'b0;
  bit src_pause = 1'b0;
  bit in_taken = 1'b0;

  function automatic longint fl14(longint x);
    return x >>> 14;
  endfunction

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  task automatic predict_contacts(pose_t s);
    longint p[3], n[3], h[3], cr[3], ln[3], m[3][3], r[3][3], w[3];
    longint off, qw, qx, qy, qz, d, dep, one;
    longint unsigned hsum, dd;
    int split[3];
    int ns, cnt, k, i;
    contact_t c;
    contact_t found[$];
    p[0] = s.px; p[1] = s.py; p[2] = s.pz;
    n[0] = s.nx; n[1] = s.ny; n[2] = s.nz;
    h[0] = hx; h[1] = hy; h[2] = hz;
    off = s.off; qw = s.qw; qx = s.qx; qy = s.qy; qz = s.qz;
    ns = 0;
    d = fl14(n[0]*p[0] + n[1]*p[1] + n[2]*p[2]) + off;
    hsum = hx*hx + hy*hy + hz*hz;
    dd = d*d;
    if (d >= 0 && d < 64'sd4294967296 && dd <= hsum) begin
      one = 64'sd1 << 28;
      r[0][0] = one - 2*(qy*qy + qz*qz);
      r[0][1] = 2*(qx*qy - qw*qz);
      r[0][2] = 2*(qx*qz + qw*qy);
      r[1][0] = 2*(qx*qy + qw*qz);
      r[1][1] = one - 2*(qx*qx + qz*qz);
      r[1][2] = 2*(qy*qz - qw*qx);
      r[2][0] = 2*(qx*qz - qw*qy);
      r[2][1] = 2*(qy*qz + qw*qx);
      r[2][2] = one - 2*(qx*qx + qy*qy);
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++) m[a][b] = fl14(r[a][b]);
      for (i = 0; i < 3; i++) begin
        ln[i] = fl14(m[0][i]*n[0] + m[1][i]*n[1] + m[2][i]*n[2]);
        if (ln[i] < -zbias) cr[i] = h[i];
        else if (ln[i] > zbias) cr[i] = -h[i];
        else begin
          split[ns] = i;
          ns++;
          cr[i] = 0;
        end
      end
      if (ns < 3) begin
        for (k = 0; k < (1 << ns); k++) begin
          if (ns >= 1) cr[split[0]] = (k & 1) ? -h[split[0]] : h[split[0]];
          if (ns == 2) cr[split[1]] = (k & 2) ? -h[split[1]] : h[split[1]];
          for (i = 0; i < 3; i++)
            w[i] = p[i] + fl14(m[i][0]*cr[0] + m[i][1]*cr[1] + m[i][2]*cr[2]);
          dep = -(fl14(n[0]*w[0] + n[1]*w[1] + n[2]*w[2]) + off);
          if (dep <= 0) break;
          c.cx = sat32(w[0] - fl14(n[0]*dep));
          c.cy = sat32(w[1] - fl14(n[1]*dep));
          c.cz = sat32(w[2] - fl14(n[2]*dep));
          c.nx = s.nx; c.ny = s.ny; c.nz = s.nz;
          c.depth = (dep > 64'sd2147483647) ? 31'h7FFFFFFF : dep[30:0];
          c.cvalid = 1'b1;
          c.last = 1'b0;
          found.push_back(c);
        end
      end
    end
    cnt = found.size();
    if (cnt == 0) begin
      c = '{default: '0};
      c.last = 1'b1;
      found.push_back(c);
    end else begin
      found[cnt-1].last = 1'b1;
    end
    foreach (found[j]) expected_contacts.push_back(found[j]);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // input acceptance, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      predict_contacts(pending_poses.pop_front());
      accepted++;
      in_taken = 1'b1;
    end
  end

  // driver
  int src_gap = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (src_gap > 0) src_gap--;
      else if (src_idle_on && $urandom_range(0, 15) == 0) src_gap = $urandom_range(1, 19);
      if (in_ch.valid && !in_taken) begin
        in_ch.valid <= 1'b1;
      end else if (pending_poses.size() > 0 && src_gap == 0 && !src_pause) begin
        in_ch.valid <= 1'b1;
        in_ch.pos_x <= pending_poses[0].px;
        in_ch.pos_y <= pending_poses[0].py;
        in_ch.pos_z <= pending_poses[0].pz;
        in_ch.plane_offset <= pending_poses[0].off;
        in_ch.quat_w <= pending_poses[0].qw;
        in_ch.quat_x <= pending_poses[0].qx;
        in_ch.quat_y <= pending_poses[0].qy;
        in_ch.quat_z <= pending_poses[0].qz;
        in_ch.normal_x <= pending_poses[0].nx;
        in_ch.normal_y <= pending_poses[0].ny;
        in_ch.normal_z <= pending_poses[0].nz;
      end else begin
        in_ch.valid <= 1'b0;
      end
      in_taken = 1'b0;
    end
  end

  // receiver
  int sink_gap = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (sink_gap > 0) sink_gap--;
      else if (sink_idle_on && $urandom_range(0, 15) == 0) sink_gap = $urandom_range(1, 19);
      out_ch.ready <= !sink_hold && sink_gap == 0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    contact_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_contacts.size() == 0) begin
        report_mismatch("result items pending", 1, 0);
      end else begin
        e = expected_contacts.pop_front();
        if (out_ch.contact_x !== e.cx) report_mismatch("contact_x", out_ch.contact_x, e.cx);
        if (out_ch.contact_y !== e.cy) report_mismatch("contact_y", out_ch.contact_y, e.cy);
        if (out_ch.contact_z !== e.cz) report_mismatch("contact_z", out_ch.contact_z, e.cz);
        if (out_ch.contact_normal_x !== e.nx)
          report_mismatch("contact_normal_x", out_ch.contact_normal_x, e.nx);
        if (out_ch.contact_normal_y !== e.ny)
          report_mismatch("contact_normal_y", out_ch.contact_normal_y, e.ny);
        if (out_ch.contact_normal_z !== e.nz)
          report_mismatch("contact_normal_z", out_ch.contact_normal_z, e.nz);
        if (out_ch.depth !== e.depth) report_mismatch("depth", out_ch.depth, e.depth);
        if (out_ch.contact_valid !== e.cvalid)
          report_mismatch("contact_valid", out_ch.contact_valid, e.cvalid);
        if (out_ch.last !== e.last) report_mismatch("last", out_ch.last, e.last);
      end
    end
  end

  task automatic write_reg(bpc_pkg::reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      bpc_pkg::REG_HALF_X: hx = val[30:0];
      bpc_pkg::REG_HALF_Y: hy = val[30:0];
      bpc_pkg::REG_HALF_Z: hz = val[30:0];
      bpc_pkg::REG_ZERO_BIAS: zbias = val[14:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    wait (pending_poses.size() == 0 && !in_ch.valid && expected_contacts.size() == 0);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      3: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_w(int span);
    if ($urandom_range(0, 9) == 0) return 32'($urandom);
    return 32'($signed($urandom_range(0, 2*span)) - span);
  endfunction

  // mostly boxes touching the plane: normal axis-aligned-ish, offset near the box
  function automatic pose_t rand_pose(int span);
    pose_t s;
    int hs;
    s.px = rand_w(span); s.py = rand_w(span); s.pz = rand_w(span);
    s.qw = rand_q(); s.qx = rand_q(); s.qy = rand_q(); s.qz = rand_q();
    if ($urandom_range(0, 3) == 0) begin
      s.qw = 16'sd16384; s.qx = 0; s.qy = 0; s.qz = 0;
    end
    s.nx = rand_q(); s.ny = rand_q(); s.nz = rand_q();
    if ($urandom_range(0, 2) == 0) begin
      s.nx = 0; s.ny = 0; s.nz = ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
    end
    hs = $urandom_range(0, 2*span);
    if ($urandom_range(0, 4) != 0)
      s.off = 32'($signed(-((longint'(s.nx)*s.px + longint'(s.ny)*s.py
                + longint'(s.nz)*s.pz) >>> 14) + hs / 2));
    else
      s.off = 32'($urandom);
    return s;
  endfunction

  task automatic run_random(int n, int span);
    repeat (n) pending_poses.push_back(rand_pose(span));
  endtask

  initial begin
    pose_t s;
    in_ch.valid = 1'b0;
    in_ch.pos_x = 0; in_ch.pos_y = 0; in_ch.pos_z = 0; in_ch.plane_offset = 0;
    in_ch.quat_w = 0; in_ch.quat_x = 0; in_ch.quat_y = 0; in_ch.quat_z = 0;
    in_ch.normal_x = 0; in_ch.normal_y = 0; in_ch.normal_z = 0;
    out_ch.ready = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: identity box, plane z, various depths and split counts, then extreme and rotated poses
    s = '{px: 0, py: 0, pz: 32'sd32768, off: 0, qw: 16'sd16384, qx: 0, qy: 0, qz: 0,
          nx: 0, ny: 0, nz: 16'sd16384};
    pending_poses.push_back(s);
    s.pz = -32'sd1; pending_poses.push_back(s);
    s.pz = 32'sd200000; pending_poses.push_back(s);
    s.pz = 0; pending_poses.push_back(s);
    s.nz = 0; s.nx = 16'sd11585; s.ny = 16'sd11585; s.pz = 32'sd10000;
    pending_poses.push_back(s);
    s.nx = 16'sd9459; s.ny = 16'sd9459; s.nz = 16'sd9459; pending_poses.push_back(s);
    s.nx = 0; s.ny = 0; s.nz = 0; pending_poses.push_back(s);
    s = '{px: 32'h7FFFFFFF, py: 32'sh80000000, pz: 32'h7FFFFFFF, off: 32'sh80000000,
          qw: -16'sd16384, qx: 16'sh7FFF, qy: 16'sh8000, qz: 16'sd16384,
          nx: 16'sh8000, ny: 16'sh7FFF, nz: -16'sd16384};
    pending_poses.push_back(s);
    s.off = 32'h7FFFFFFF; pending_poses.push_back(s);
    s = '{px: 32'h7FFF0000, py: 0, pz: 0, off: 32'sh80010000, qw: 16'sd16384, qx: 0,
          qy: 0, qz: 0, nx: 16'sd16384, ny: 0, nz: 0};
    pending_poses.push_back(s);
    s.qw = 0; s.qx = 16'sd16384; pending_poses.push_back(s);
    s.qx = 16'sd11585; s.qy = 16'sd11585; s.qw = 0; pending_poses.push_back(s);
    run_random(10, 200000);
    drain();

    // extremes of configuration
    write_reg(bpc_pkg::REG_HALF_X, 32'h7FFFFFFF);
    write_reg(bpc_pkg::REG_HALF_Y, 32'h0);
    write_reg(bpc_pkg::REG_HALF_Z, 32'h00400000);
    write_reg(bpc_pkg::REG_ZERO_BIAS, 32'd16384);
    run_random(40, 1 << 22);
    drain();
    write_reg(bpc_pkg::REG_ZERO_BIAS, 32'd0);
    write_reg(bpc_pkg::REG_HALF_Y, 32'hFFFFFFFF);
    run_random(40, 1 << 30);
    drain();

    // long receiver hold while the sender keeps offering
    write_reg(bpc_pkg::REG_HALF_X, 32'd65536);
    write_reg(bpc_pkg::REG_HALF_Y, 32'd131072);
    write_reg(bpc_pkg::REG_HALF_Z, 32'd32768);
    write_reg(bpc_pkg::REG_ZERO_BIAS, 32'd300);
    sink_hold = 1'b1;
    run_random(60, 300000);
    repeat (300) @(negedge clk_i);
    sink_hold = 1'b0;
    wait (pending_poses.size() <= 30);
    src_pause = 1'b1;
    wait (expected_contacts.size() == 0 && !in_ch.valid);
    src_pause = 1'b0;
    drain();

    write_reg(bpc_pkg::REG_ZERO_BIAS, $urandom_range(0, 2000));
    write_reg(bpc_pkg::REG_HALF_X, $urandom_range(0, 1 << 20));
    run_random(80, 1 << 21);
    drain();

    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    run_random(80, 300000);
    drain();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
+incdir+rtl/core
rtl/core/bpc_pkg.sv
rtl/core/bpc_in_if.sv
rtl/core/bpc_out_if.sv
rtl/core/box_plane_contact_generator.sv
rtl/core/bpc_checker.sv
test/tb_top.sv
